### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NMSH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmsh assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NMSH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmsh assertion failed");

`endif

### hdl/nmsh_pkg.sv
package nmsh_pkg;

  localparam int COORD_W   = 33;
  localparam int ID_W      = 32;
  localparam int KIND_W    = 3;
  localparam int DIST_W    = 25;
  localparam int PADDR_W   = 4;
  localparam int MUL_W     = 70;
  localparam int MUL_DIG   = 14;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_STEPS = 26;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_ADD_MARKER = 2'd1,
    OP_ADD_SEG    = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_NO_HIT = 2'd0,
    ST_HIT    = 2'd1,
    ST_LOADED = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic [1:0] REG_ZOOM = 2'd0;
  localparam logic [1:0] REG_PIPE = 2'd1;
  localparam logic [1:0] REG_LINK = 2'd2;

  localparam logic [4:0] ZOOM_BOX40 = 5'd19;
  localparam logic [4:0] ZOOM_BOX30 = 5'd18;
  localparam logic [4:0] ZOOM_BOX20 = 5'd17;
  localparam logic [9:0] HALF_40    = 10'd320;
  localparam logic [9:0] HALF_30    = 10'd240;
  localparam logic [9:0] HALF_20    = 10'd160;
  localparam logic [9:0] HALF_10    = 10'd80;
  localparam logic [7:0] LINK_RESET = 8'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ID_W-1:0]           id;
    logic [KIND_W-1:0]         kind;
  } marker_entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [ID_W-1:0]           id;
    logic [KIND_W-1:0]         kind;
    logic                      pipe;
  } seg_entry_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [DIST_W-1:0]         limit;
  } seg_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [DIST_W-1:0] sq_dist;
  } seg_rsp_t;

  function automatic logic signed [COORD_W:0] sx34(logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic [9:0] half_width(logic [4:0] zoom);
    logic [9:0] hw;
    priority if (zoom == ZOOM_BOX40) hw = HALF_40;
    else if (zoom == ZOOM_BOX30) hw = HALF_30;
    else if (zoom == ZOOM_BOX20) hw = HALF_20;
    else hw = HALF_10;
    return hw;
  endfunction

endpackage

### hdl/nmsh_ram.sv
module nmsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/nmsh_mul.sv
module nmsh_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nmsh_pkg::MUL_W-1:0]  a,
  input  logic [nmsh_pkg::MUL_W-1:0]  b,
  output logic                         done,
  output logic [nmsh_pkg::PROD_W-1:0] prod
);

  import nmsh_pkg::*;

  logic [MUL_W-1:0]         a_q;
  logic [MUL_W-1:0]         b_q;
  logic [PROD_W-1:0]        acc;
  logic [2:0]               cnt;
  logic                     run;
  logic [MUL_W+MUL_DIG-1:0] pp;

  assign pp   = {{MUL_DIG{1'b0}}, a_q} * {{MUL_W{1'b0}}, b_q[MUL_W-1 -: MUL_DIG]};
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q <= a;
        b_q <= b;
        acc <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        acc <= (acc << MUL_DIG) + {{(PROD_W-MUL_W-MUL_DIG){1'b0}}, pp};
        b_q <= b_q << MUL_DIG;
        cnt <= cnt + 3'd1;
        if (cnt == 3'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/nmsh_seg_unit.sv
module nmsh_seg_unit (
  input  logic               clk,
  input  logic               rst,
  input  nmsh_pkg::seg_req_t req,
  output nmsh_pkg::seg_rsp_t rsp
);

  import nmsh_pkg::*;

  typedef enum logic [4:0] {
    SU_IDLE  = 5'b00001,
    SU_ISSUE = 5'b00010,
    SU_WAIT  = 5'b00100,
    SU_DIV   = 5'b01000,
    SU_FIN   = 5'b10000
  } su_state_t;

  localparam logic [3:0] K_PXDX  = 4'd0;
  localparam logic [3:0] K_PYDY  = 4'd1;
  localparam logic [3:0] K_DXDX  = 4'd2;
  localparam logic [3:0] K_DYDY  = 4'd3;
  localparam logic [3:0] K_PXDY  = 4'd4;
  localparam logic [3:0] K_PYDX  = 4'd5;
  localparam logic [3:0] K_CROSS = 4'd6;
  localparam logic [3:0] K_VXVX  = 4'd7;
  localparam logic [3:0] K_VYVY  = 4'd8;
  localparam logic [33:0] FAR_LIMIT = 34'd33554432;

  su_state_t          state;
  logic [3:0]         k;
  logic signed [33:0] px, py, dx, dy, vx, vy;
  logic signed [69:0] acc;
  logic [68:0]        len;
  logic [134:0]       rem;
  logic [93:0]        dsr;
  logic [25:0]        q;
  logic [4:0]         dj;
  logic [51:0]        e;
  logic [DIST_W-1:0]  limit;
  logic               hit_r;
  logic [DIST_W-1:0]  dist_r;

  logic               mul_start;
  logic               mul_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic               neg;
  logic signed [69:0] prod_s, term;
  logic [69:0]        acc_mag;
  logic [68:0]        len_sum;
  logic [51:0]        e_sum;
  logic               far;
  logic               ge;
  logic [25:0]        q_next;

  function automatic logic [33:0] mag34(logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  nmsh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg   = 1'b0;
    unique case (k)
      K_PXDX: begin
        mul_a = MUL_W'(mag34(px));
        mul_b = MUL_W'(mag34(dx));
        neg   = px[33] ^ dx[33];
      end
      K_PYDY: begin
        mul_a = MUL_W'(mag34(py));
        mul_b = MUL_W'(mag34(dy));
        neg   = py[33] ^ dy[33];
      end
      K_DXDX: begin
        mul_a = MUL_W'(mag34(dx));
        mul_b = MUL_W'(mag34(dx));
      end
      K_DYDY: begin
        mul_a = MUL_W'(mag34(dy));
        mul_b = MUL_W'(mag34(dy));
      end
      K_PXDY: begin
        mul_a = MUL_W'(mag34(px));
        mul_b = MUL_W'(mag34(dy));
        neg   = px[33] ^ dy[33];
      end
      K_PYDX: begin
        mul_a = MUL_W'(mag34(py));
        mul_b = MUL_W'(mag34(dx));
        neg   = py[33] ^ dx[33];
      end
      K_CROSS: begin
        mul_a = acc_mag;
        mul_b = acc_mag;
      end
      K_VXVX: begin
        mul_a = MUL_W'(mag34(vx));
        mul_b = MUL_W'(mag34(vx));
      end
      K_VYVY: begin
        mul_a = MUL_W'(mag34(vy));
        mul_b = MUL_W'(mag34(vy));
      end
      default: begin
      end
    endcase
  end

  assign acc_mag   = acc[69] ? 70'(-acc) : 70'(acc);
  assign prod_s    = $signed({1'b0, prod[68:0]});
  assign term      = neg ? -prod_s : prod_s;
  assign len_sum   = len + prod[68:0];
  assign e_sum     = e + prod[51:0];
  assign far       = (mag34(vx) > FAR_LIMIT) || (mag34(vy) > FAR_LIMIT);
  assign mul_start = (state == SU_ISSUE) && !((k == K_VXVX) && far);
  assign ge        = rem >= {41'b0, dsr};
  assign q_next    = {q[24:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SU_IDLE;
    end else begin
      unique case (state)
        SU_IDLE: begin
          if (req.start) begin
            px    <= sx34(req.qx) - sx34(req.sx);
            py    <= sx34(req.qy) - sx34(req.sy);
            dx    <= sx34(req.ex) - sx34(req.sx);
            dy    <= sx34(req.ey) - sx34(req.sy);
            limit <= req.limit;
            k     <= K_PXDX;
            state <= SU_ISSUE;
          end
        end
        SU_ISSUE: begin
          if ((k == K_VXVX) && far) begin
            hit_r  <= 1'b0;
            dist_r <= '0;
            state  <= SU_FIN;
          end else begin
            state <= SU_WAIT;
          end
        end
        SU_WAIT: begin
          if (mul_done) begin
            state <= SU_ISSUE;
            unique case (k)
              K_PXDX: begin
                acc <= term;
                k   <= K_PYDY;
              end
              K_PYDY: begin
                acc <= acc + term;
                k   <= K_DXDX;
              end
              K_DXDX: begin
                len <= prod[68:0];
                k   <= K_DYDY;
              end
              K_DYDY: begin
                len <= len_sum;
                if (acc <= 70'sd0) begin
                  vx <= px;
                  vy <= py;
                  k  <= K_VXVX;
                end else if (acc >= $signed({1'b0, len_sum})) begin
                  vx <= px - dx;
                  vy <= py - dy;
                  k  <= K_VXVX;
                end else begin
                  k <= K_PXDY;
                end
              end
              K_PXDY: begin
                acc <= term;
                k   <= K_PYDX;
              end
              K_PYDX: begin
                acc <= acc - term;
                k   <= K_CROSS;
              end
              K_CROSS: begin
                rem   <= prod[134:0];
                dsr   <= {len, 25'b0};
                q     <= '0;
                dj    <= 5'(DIV_STEPS - 1);
                state <= SU_DIV;
              end
              K_VXVX: begin
                e <= prod[51:0];
                k <= K_VYVY;
              end
              K_VYVY: begin
                hit_r  <= e_sum <= {27'b0, limit};
                dist_r <= e_sum[DIST_W-1:0];
                state  <= SU_FIN;
              end
              default: begin
                hit_r <= 1'b0;
                state <= SU_FIN;
              end
            endcase
          end
        end
        SU_DIV: begin
          if (ge) begin
            rem <= rem - {41'b0, dsr};
          end
          dsr <= dsr >> 1;
          q   <= q_next;
          dj  <= dj - 5'd1;
          if (dj == 5'd0) begin
            hit_r  <= !q_next[25] && (q_next[24:0] <= limit);
            dist_r <= q_next[24:0];
            state  <= SU_FIN;
          end
        end
        SU_FIN: begin
          state <= SU_IDLE;
        end
        default: begin
          state <= SU_IDLE;
        end
      endcase
    end
  end

  assign rsp.done    = (state == SU_FIN);
  assign rsp.hit     = hit_r;
  assign rsp.sq_dist = dist_r;

endmodule

### hdl/nearest_marker_segment_hit_test.sv
// Channel   Signals                                         Transfer when
// command   start, busy, op, pos_x..item_type               start && !busy
// result    done, status, hit_id, hit_type                  done (one cycle)
// config    psel, penable, pwrite, paddr, pwdata, prdata    psel && penable && pwrite
// A clear or a load is answered in the cycle after it is accepted.
// A query sweeps the marker memory one entry a cycle.
// Without a marker hit it then reads each stored segment; each segment of the searched
// class is worked in the shared 70 x 14 bit multiplier (end point) or in it and the
// 26-step divider (interior); pipes follow only a device miss.
// Reset is synchronous; it clears both counts, zoom and pipe code and sets the link distance
// to 7; memories are not cleared. The receiver cannot stall results; busy holds off commands while a query runs.
module nearest_marker_segment_hit_test #(
  parameter int MARKER_DEPTH  = 1024,
  parameter int SEGMENT_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           op,
  input  logic signed [nmsh_pkg::COORD_W-1:0] pos_x,
  input  logic signed [nmsh_pkg::COORD_W-1:0] pos_y,
  input  logic signed [nmsh_pkg::COORD_W-1:0] end_x,
  input  logic signed [nmsh_pkg::COORD_W-1:0] end_y,
  input  logic [nmsh_pkg::ID_W-1:0]           item_id,
  input  logic [nmsh_pkg::KIND_W-1:0]         item_type,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [nmsh_pkg::ID_W-1:0]           hit_id,
  output logic [nmsh_pkg::KIND_W-1:0]         hit_type,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nmsh_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import nmsh_pkg::*;

  localparam int MAW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
  localparam int MCW = $clog2(MARKER_DEPTH + 1);
  localparam int SAW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
  localparam int SCW = $clog2(SEGMENT_DEPTH + 1);

  typedef enum logic [5:0] {
    T_IDLE  = 6'b000001,
    T_MSCAN = 6'b000010,
    T_SREAD = 6'b000100,
    T_SWAIT = 6'b001000,
    T_SCALC = 6'b010000,
    T_DONE  = 6'b100000
  } top_state_t;

  top_state_t state;

  logic [4:0]  zoom_level;
  logic [2:0]  pipe_type_code;
  logic [7:0]  link_hit_distance;

  logic [MCW-1:0] m_count;
  logic [SCW-1:0] s_count;
  logic [MCW-1:0] m_idx;
  logic [SCW-1:0] s_idx;
  logic           m_vld;
  logic           found;
  logic           pass;
  logic [19:0]    m_best;
  logic [DIST_W-1:0] s_best;
  logic [ID_W-1:0]   best_id, cand_id;
  logic [KIND_W-1:0] best_type, cand_type;
  logic signed [COORD_W-1:0] qx, qy;

  logic accept, cfg_wr;
  logic m_full, s_full, m_we, s_we, m_re, s_re, m_more, s_more;
  marker_entry_t m_wr, m_ent;
  seg_entry_t    s_wr, s_ent;
  logic [$bits(marker_entry_t)-1:0] m_rdata;
  logic [$bits(seg_entry_t)-1:0]    s_rdata;

  logic signed [33:0] mdx, mdy, hws;
  logic [9:0]         amx, amy;
  logic [19:0]        m_dist;
  logic               m_take;
  logic [15:0]        link_sq;
  logic [DIST_W-1:0]  s_init;

  seg_req_t seg_req;
  seg_rsp_t seg_rsp;

  assign busy   = (state != T_IDLE);
  assign accept = start && (state == T_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_ZOOM: prdata = {27'b0, zoom_level};
      REG_PIPE: prdata = {29'b0, pipe_type_code};
      REG_LINK: prdata = {24'b0, link_hit_distance};
      default:  prdata = '0;
    endcase
  end

  assign m_full = (m_count == MCW'(MARKER_DEPTH));
  assign s_full = (s_count == SCW'(SEGMENT_DEPTH));
  assign m_we   = accept && (op == OP_ADD_MARKER) && !m_full;
  assign s_we   = accept && (op == OP_ADD_SEG) && !s_full;
  assign m_more = (m_idx < m_count);
  assign s_more = (s_idx < s_count);
  assign m_re   = (state == T_MSCAN) && m_more;
  assign s_re   = (state == T_SREAD) && s_more;

  always_comb begin
    m_wr.x      = pos_x;
    m_wr.y      = pos_y;
    m_wr.id     = item_id;
    m_wr.kind   = item_type;
    s_wr.sx     = pos_x;
    s_wr.sy     = pos_y;
    s_wr.ex     = end_x;
    s_wr.ey     = end_y;
    s_wr.id     = item_id;
    s_wr.kind   = item_type;
    s_wr.pipe   = (item_type == pipe_type_code);
  end

  nmsh_ram #(
    .WIDTH ($bits(marker_entry_t)),
    .DEPTH (MARKER_DEPTH)
  ) u_marker_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_count[MAW-1:0]),
    .wdata (m_wr),
    .re    (m_re),
    .raddr (m_idx[MAW-1:0]),
    .rdata (m_rdata)
  );

  nmsh_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (SEGMENT_DEPTH)
  ) u_seg_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_count[SAW-1:0]),
    .wdata (s_wr),
    .re    (s_re),
    .raddr (s_idx[SAW-1:0]),
    .rdata (s_rdata)
  );

  assign m_ent  = marker_entry_t'(m_rdata);
  assign s_ent  = seg_entry_t'(s_rdata);

  assign hws    = $signed({24'b0, half_width(zoom_level)});
  assign mdx    = sx34(qx) - sx34(m_ent.x);
  assign mdy    = sx34(qy) - sx34(m_ent.y);
  assign amx    = mdx[9] ? 10'(-mdx[9:0]) : mdx[9:0];
  assign amy    = mdy[9] ? 10'(-mdy[9:0]) : mdy[9:0];
  assign m_dist = 20'(amx) * 20'(amx) + 20'(amy) * 20'(amy);
  assign m_take = (mdx <= hws) && (mdx >= -hws) && (mdy <= hws) && (mdy >= -hws)
                  && (!found || (m_dist < m_best));

  assign link_sq = 16'(link_hit_distance) * 16'(link_hit_distance);
  assign s_init  = {1'b0, link_sq, 8'b0};

  always_comb begin
    seg_req.start = (state == T_SWAIT) && (s_ent.pipe == pass);
    seg_req.qx    = qx;
    seg_req.qy    = qy;
    seg_req.sx    = s_ent.sx;
    seg_req.sy    = s_ent.sy;
    seg_req.ex    = s_ent.ex;
    seg_req.ey    = s_ent.ey;
    seg_req.limit = s_best;
  end

  nmsh_seg_unit u_seg (
    .clk (clk),
    .rst (rst),
    .req (seg_req),
    .rsp (seg_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= T_IDLE;
      done              <= 1'b0;
      m_count           <= '0;
      s_count           <= '0;
      m_vld             <= 1'b0;
      found             <= 1'b0;
      pass              <= 1'b0;
      zoom_level        <= '0;
      pipe_type_code    <= '0;
      link_hit_distance <= LINK_RESET;
    end else begin
      done  <= 1'b0;
      m_vld <= m_re;
      if (m_re) begin
        m_idx <= m_idx + MCW'(1);
      end
      if (cfg_wr) begin
        unique case (paddr[PADDR_W-1:2])
          REG_ZOOM: zoom_level        <= pwdata[4:0];
          REG_PIPE: pipe_type_code    <= pwdata[2:0];
          REG_LINK: link_hit_distance <= pwdata[7:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        T_IDLE: begin
          if (start) begin
            unique case (op)
              OP_CLEAR: begin
                m_count  <= '0;
                s_count  <= '0;
                done     <= 1'b1;
                status   <= ST_LOADED;
                hit_id   <= '0;
                hit_type <= '0;
              end
              OP_ADD_MARKER: begin
                if (!m_full) begin
                  m_count <= m_count + MCW'(1);
                end
                done     <= 1'b1;
                status   <= m_full ? ST_FULL : ST_LOADED;
                hit_id   <= '0;
                hit_type <= '0;
              end
              OP_ADD_SEG: begin
                if (!s_full) begin
                  s_count <= s_count + SCW'(1);
                end
                done     <= 1'b1;
                status   <= s_full ? ST_FULL : ST_LOADED;
                hit_id   <= '0;
                hit_type <= '0;
              end
              OP_QUERY: begin
                qx    <= pos_x;
                qy    <= pos_y;
                found <= 1'b0;
                m_idx <= '0;
                state <= T_MSCAN;
              end
              default: begin
              end
            endcase
          end
        end
        T_MSCAN: begin
          if (m_vld && m_take) begin
            found     <= 1'b1;
            m_best    <= m_dist;
            best_id   <= m_ent.id;
            best_type <= m_ent.kind;
          end
          if (!m_re && !m_vld) begin
            if (found) begin
              state <= T_DONE;
            end else begin
              pass   <= 1'b0;
              s_idx  <= '0;
              s_best <= s_init;
              state  <= T_SREAD;
            end
          end
        end
        T_SREAD: begin
          if (s_more) begin
            state <= T_SWAIT;
          end else if (found || pass) begin
            state <= T_DONE;
          end else begin
            pass   <= 1'b1;
            s_idx  <= '0;
            s_best <= s_init;
          end
        end
        T_SWAIT: begin
          if (s_ent.pipe == pass) begin
            cand_id   <= s_ent.id;
            cand_type <= s_ent.kind;
            state     <= T_SCALC;
          end else begin
            s_idx <= s_idx + SCW'(1);
            state <= T_SREAD;
          end
        end
        T_SCALC: begin
          if (seg_rsp.done) begin
            if (seg_rsp.hit) begin
              found     <= 1'b1;
              s_best    <= seg_rsp.sq_dist;
              best_id   <= cand_id;
              best_type <= cand_type;
            end
            s_idx <= s_idx + SCW'(1);
            state <= T_SREAD;
          end
        end
        T_DONE: begin
          done     <= 1'b1;
          status   <= found ? ST_HIT : ST_NO_HIT;
          hit_id   <= found ? best_id : '0;
          hit_type <= found ? best_type : '0;
          state    <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/nmsh_checker.sv
`include "assert_macros.svh"

module nmsh_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    op,
  input logic [1:0]                    status,
  input logic [nmsh_pkg::ID_W-1:0]    hit_id,
  input logic [nmsh_pkg::KIND_W-1:0]  hit_type
);

  import nmsh_pkg::*;

  logic accepted;

  assign accepted = start && !busy;

  `NMSH_ASSERT_IMP(a_done_when_free, clk, rst, done, !busy)
  `NMSH_ASSERT_IMP(a_miss_is_zero, clk, rst, done && (status != ST_HIT), (hit_id == '0) && (hit_type == '0))
  `NMSH_ASSERT_NXT(a_load_answered, clk, rst, accepted && (op != OP_QUERY), done && ((status == ST_LOADED) || (status == ST_FULL)))
  `NMSH_ASSERT_NXT(a_query_holds, clk, rst, accepted && (op == OP_QUERY), busy && !done)

endmodule

bind nearest_marker_segment_hit_test nmsh_checker u_nmsh_checker (.*);

### tb/nearest_marker_segment_hit_test_test.sv
module nearest_marker_segment_hit_test_test;
  import nmsh_pkg::*;

  localparam int MARKER_CAP = 1024;
  localparam int SEG_CAP = 4096;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic signed [159:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic [ID_W-1:0] id;
    logic [KIND_W-1:0] kind;
  } marker_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic [ID_W-1:0] id;
    logic [KIND_W-1:0] kind;
    bit pipe;
  } segment_t;

  typedef struct {
    status_t st;
    logic [ID_W-1:0] id;
    logic [KIND_W-1:0] kind;
  } pick_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] op = OP_CLEAR;
  coord_t pos_x = '0, pos_y = '0, end_x = '0, end_y = '0;
  logic [ID_W-1:0] item_id = '0;
  logic [KIND_W-1:0] item_type = '0;
  logic done;
  logic [1:0] status;
  logic [ID_W-1:0] hit_id;
  logic [KIND_W-1:0] hit_type;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nearest_marker_segment_hit_test DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  marker_t markers[$];
  segment_t segments[$];
  pick_t picks_pending[$];
  logic [4:0] zoom_reg = 5'd0;
  logic [2:0] pipe_reg = 3'd0;
  logic [7:0] link_reg = LINK_RESET;
  int failures = 0;
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && done) begin
      if (picks_pending.size() == 0) begin
        $error("unexpected result transfer status=%0d", status);
        failures++;
      end else begin
        want = picks_pending.pop_front();
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          failures++;
        end
        if (hit_id !== want.id) begin
          $error("hit_id expected %0h actual %0h", want.id, hit_id);
          failures++;
        end
        if (hit_type !== want.kind) begin
          $error("hit_type expected %0d actual %0d", want.kind, hit_type);
          failures++;
        end
      end
    end
  end

  // Squared distance from the query to a segment, with clamped projection.
  function automatic wide_t segment_distance(segment_t s, coord_t qx, coord_t qy);
    wide_t px, py, dx, dy, dot, len, ax, ay, cross_p;
    px = wide_t'(qx) - wide_t'(s.sx);
    py = wide_t'(qy) - wide_t'(s.sy);
    dx = wide_t'(s.ex) - wide_t'(s.sx);
    dy = wide_t'(s.ey) - wide_t'(s.sy);
    dot = px * dx + py * dy;
    len = dx * dx + dy * dy;
    if (dot <= 0) begin
      ax = px;
      ay = py;
    end else if (dot >= len) begin
      ax = wide_t'(qx) - wide_t'(s.ex);
      ay = wide_t'(qy) - wide_t'(s.ey);
    end else begin
      cross_p = px * dy - py * dx;
      return (cross_p * cross_p) / len;
    end
    return ax * ax + ay * ay;
  endfunction

  function automatic pick_t predict_pick(op_t cmd, coord_t x, coord_t y, coord_t x2,
                                         coord_t y2, logic [ID_W-1:0] id,
                                         logic [KIND_W-1:0] kind);
    pick_t r;
    wide_t hw, dx, dy, d, best;
    bit found;
    segment_t s;
    r.st = ST_LOADED;
    r.id = '0;
    r.kind = '0;
    case (cmd)
      OP_CLEAR: begin
        markers.delete();
        segments.delete();
      end
      OP_ADD_MARKER: begin
        if (markers.size() >= MARKER_CAP) r.st = ST_FULL;
        else markers.push_back('{x, y, id, kind});
      end
      OP_ADD_SEG: begin
        if (segments.size() >= SEG_CAP) r.st = ST_FULL;
        else segments.push_back('{x, y, x2, y2, id, kind, kind == pipe_reg});
      end
      default: begin
        hw = zoom_reg == ZOOM_BOX40 ? 320 : zoom_reg == ZOOM_BOX30 ? 240 :
             zoom_reg == ZOOM_BOX20 ? 160 : 80;
        found = 0;
        best = 0;
        foreach (markers[i]) begin
          dx = wide_t'(x) - wide_t'(markers[i].x);
          dy = wide_t'(y) - wide_t'(markers[i].y);
          if (dx > hw || dx < -hw || dy > hw || dy < -hw) continue;
          d = dx * dx + dy * dy;
          if (!found || d < best) begin
            found = 1;
            best = d;
            r.id = markers[i].id;
            r.kind = markers[i].kind;
          end
        end
        for (int pass = 0; pass < 2 && !found; pass++) begin
          best = wide_t'(link_reg) * 16 * wide_t'(link_reg) * 16;
          foreach (segments[i]) begin
            s = segments[i];
            if (s.pipe != pass) continue;
            d = segment_distance(s, x, y);
            if (d <= best) begin
              found = 1;
              best = d;
              r.id = s.id;
              r.kind = s.kind;
            end
          end
        end
        r.st = found ? ST_HIT : ST_NO_HIT;
        if (!found) begin
          r.id = '0;
          r.kind = '0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_command(op_t cmd, coord_t x, coord_t y, coord_t x2, coord_t y2,
                              logic [ID_W-1:0] id, logic [KIND_W-1:0] kind, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1;
    op = cmd;
    pos_x = x;
    pos_y = y;
    end_x = x2;
    end_y = y2;
    item_id = id;
    item_type = kind;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    picks_pending.push_back(predict_pick(cmd, x, y, x2, y2, id, kind));
  endtask

  task automatic send_random_gap(op_t cmd, coord_t x, coord_t y, coord_t x2, coord_t y2,
                                 logic [ID_W-1:0] id, logic [KIND_W-1:0] kind);
    send_command(cmd, x, y, x2, y2, id, kind,
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
  endtask

  task automatic drain;
    @(negedge clk);
    start = 0;
    while (picks_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = PADDR_W'(index) << 2;
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    case (index)
      REG_ZOOM: zoom_reg = value[4:0];
      REG_PIPE: pipe_reg = value[2:0];
      default: link_reg = value[7:0];
    endcase
  endtask

  function automatic coord_t any_coord();
    return coord_t'({$urandom, $urandom});
  endfunction

  function automatic coord_t near_coord(coord_t base, int spread);
    return base + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic test_empty_and_clear;
    send_random_gap(OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_random_gap(OP_ADD_MARKER, 0, 0, 0, 0, 32'hFFFF_FFFF, 3'd7);
    send_random_gap(OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                    $urandom, 3'd5);
    send_random_gap(OP_QUERY, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_marker_box;
    logic [4:0] zooms[5] = '{5'd19, 5'd18, 5'd17, 5'd0, 5'd31};
    int halves[5] = '{320, 240, 160, 80, 80};
    foreach (zooms[z]) begin
      write_register(REG_ZOOM, zooms[z]);
      send_random_gap(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      send_random_gap(OP_ADD_MARKER, coord_t'(-33'sd4294967296), 33'sd4294967295, 0, 0,
                      32'h0000_0001, 3'd1);
      send_random_gap(OP_ADD_MARKER, 100, 100, 0, 0, 32'hA5A5_0002, 3'd2);
      send_random_gap(OP_ADD_MARKER, 100, 100, 0, 0, 32'hA5A5_0003, 3'd3);
      send_random_gap(OP_QUERY, 100 + halves[z], 100 - halves[z], 0, 0, 0, 0);
      send_random_gap(OP_QUERY, 100 + halves[z] + 1, 100, 0, 0, 0, 0);
      send_random_gap(OP_QUERY, coord_t'(-33'sd4294967296) + halves[z], 33'sd4294967295,
                      0, 0, 0, 0);
      drain();
    end
  endtask

  task automatic test_segments;
    write_register(REG_ZOOM, 5'd0);
    write_register(REG_PIPE, 3'd4);
    write_register(REG_LINK, 8'd7);
    send_random_gap(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_random_gap(OP_ADD_SEG, 0, 0, 1600, 0, 32'h100, 3'd1);
    send_random_gap(OP_ADD_SEG, 0, 50, 1600, 50, 32'h101, 3'd2);
    send_random_gap(OP_ADD_SEG, 3000, 3000, 3000, 3000, 32'h102, 3'd0);
    send_random_gap(OP_ADD_SEG, 5000, 0, 6000, 0, 32'h103, 3'd4);
    send_random_gap(OP_QUERY, 800, 25, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 1650, 10, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, -60, 0, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 3050, 3050, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 5500, 100, 0, 0, 0, 0);
    drain();
    write_register(REG_PIPE, 3'd1);
    write_register(REG_LINK, 8'd0);
    send_random_gap(OP_QUERY, 800, 0, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 801, 1, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 5500, 0, 0, 0, 0, 0);
    drain();
    write_register(REG_LINK, 8'd255);
    send_random_gap(OP_ADD_SEG, coord_t'(-33'sd4294967296), coord_t'(-33'sd4294967296),
                    33'sd4294967295, 33'sd4294967295, 32'hFFFF_FFFF, 3'd7);
    send_random_gap(OP_QUERY, 20000, 20000, 0, 0, 0, 0);
    send_random_gap(OP_QUERY, 10, 4000, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random;
    coord_t cx, cy, qx, qy;
    int roll;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_register(REG_ZOOM, (phase == 0) ? 5'd31 : $urandom_range(16, 19));
      write_register(REG_PIPE, $urandom_range(0, 7));
      write_register(REG_LINK, (phase == 1) ? 8'd255 : (phase == 2) ? 8'd0 :
                     $urandom_range(0, 40));
      send_random_gap(OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                      $urandom, $urandom);
      cx = any_coord();
      cy = any_coord();
      for (int n = 0; n < 9; n++) begin
        roll = $urandom_range(0, 19);
        qx = near_coord(cx, 600);
        qy = near_coord(cy, 600);
        if (roll < 5)
          send_random_gap(OP_ADD_MARKER, qx, qy, any_coord(), any_coord(), $urandom,
                          $urandom);
        else if (roll < 11)
          send_random_gap(OP_ADD_SEG, qx, qy, near_coord(qx, 800), near_coord(qy, 800),
                          $urandom, $urandom);
        else if (roll < 12)
          send_random_gap(OP_ADD_SEG, any_coord(), any_coord(), any_coord(), any_coord(),
                          $urandom, $urandom);
        else if (roll < 13)
          send_random_gap(OP_CLEAR, qx, qy, 0, 0, 0, 0);
        else
          send_random_gap(OP_QUERY, qx, qy, any_coord(), any_coord(), $urandom, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_empty_and_clear();
    test_marker_box();
    test_segments();
    test_random();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
